// ===== design/kspd_pkg.sv =====
package kspd_pkg;

  // Data path widths.
  localparam int DATA_BITS  = 24;
  localparam int PHASE_BITS = 16;
  localparam int COORD_BITS = 24;
  localparam int GUARD      = 8;
  localparam int FRAC_BITS  = 30;
  localparam int ITERS      = 24;
  localparam int ANG_BITS   = 32;
  // CORDIC x/y width leaves headroom for the rotation growth.
  localparam int CW         = DATA_BITS + GUARD + 3;
  // Angle accumulator width.
  localparam int ZW         = ANG_BITS + 1;
  // Width of the gain-compensated sample before extension.
  localparam int GW         = DATA_BITS + GUARD + 1;
  // Width of the rounded result before saturation.
  localparam int RW         = CW - GUARD;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int AXES_BITS     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_X   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Y   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Z   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXES_USED = 2'd3;

  localparam logic [AXES_BITS-1:0] AXES_RESET = 2'd3;

  // CORDIC gain 0.60725... scaled by 2^31.
  localparam logic signed [31:0] GAIN_K = 32'sd1304065748;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [ANG_BITS-1:0] ATAN_TURNS [ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] k_x;
    logic signed [COORD_BITS-1:0] k_y;
    logic signed [COORD_BITS-1:0] k_z;
    logic signed [DATA_BITS-1:0]  sample_re;
    logic signed [DATA_BITS-1:0]  sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [CFG_DATA_BITS-1:0] shift_x;
    logic signed [CFG_DATA_BITS-1:0] shift_y;
    logic signed [CFG_DATA_BITS-1:0] shift_z;
    logic [AXES_BITS-1:0]            axes_used;
  } cfg_t;

  // Rotator state carried from stage to stage.
  typedef struct packed {
    logic                 byp;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] out_re;
    logic signed [DATA_BITS-1:0] out_im;
    logic                        saturated;
  } out_item_t;

endpackage

// ===== design/kspd_in_if.sv =====
interface kspd_in_if;
  import kspd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  k_x;
  logic signed [COORD_BITS-1:0]  k_y;
  logic signed [COORD_BITS-1:0]  k_z;
  logic signed [DATA_BITS-1:0]   sample_re;
  logic signed [DATA_BITS-1:0]   sample_im;

  modport source (output valid, k_x, k_y, k_z, sample_re, sample_im, input ready);
  modport sink   (input valid, k_x, k_y, k_z, sample_re, sample_im, output ready);
endinterface

// ===== design/kspd_out_if.sv =====
interface kspd_out_if;
  import kspd_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] out_re;
  logic signed [DATA_BITS-1:0] out_im;
  logic                        saturated;

  modport source (output valid, out_re, out_im, saturated, input ready);
  modport sink   (input valid, out_re, out_im, saturated, output ready);
endinterface

// ===== design/kspd_cfg_if.sv =====
interface kspd_cfg_if;
  import kspd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/kspd_front.sv =====
module kspd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_in,
  input  kspd_pkg::in_item_t item,
  input  kspd_pkg::cfg_t     cfg,
  output logic               v_out,
  output kspd_pkg::cordic_t  st_out
);
  import kspd_pkg::*;

  // Stage one: dot product terms, gain compensation and bypass decision.
  logic signed [2*COORD_BITS-1:0]  mx, my, mz;
  logic signed [DATA_BITS+31:0]    mre, mim;
  logic signed [GW-1:0]            gre, gim;
  logic                            use_y, use_z, byp;

  logic                  v1_r;
  logic [FRAC_BITS-1:0]  px_r, py_r, pz_r;
  logic signed [CW-1:0]  gre_r, gim_r;
  logic signed [DATA_BITS-1:0] re1_r, im1_r;
  logic                  byp1_r;

  assign mx    = cfg.shift_x * item.k_x;
  assign my    = cfg.shift_y * item.k_y;
  assign mz    = cfg.shift_z * item.k_z;
  assign mre   = item.sample_re * GAIN_K;
  assign mim   = item.sample_im * GAIN_K;
  assign gre   = mre[DATA_BITS+31:31-GUARD];
  assign gim   = mim[DATA_BITS+31:31-GUARD];
  assign use_y = (cfg.axes_used >= AXES_BITS'(2));
  assign use_z = (cfg.axes_used == AXES_BITS'(3));
  assign byp   = (cfg.axes_used == '0) ||
                 (cfg.shift_x == '0 && cfg.shift_y == '0 && cfg.shift_z == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= mx[FRAC_BITS-1:0];
      py_r   <= use_y ? my[FRAC_BITS-1:0] : '0;
      pz_r   <= use_z ? mz[FRAC_BITS-1:0] : '0;
      gre_r  <= CW'(gre);
      gim_r  <= CW'(gim);
      re1_r  <= item.sample_re;
      im1_r  <= item.sample_im;
      byp1_r <= byp;
    end
  end

  // Stage two: fractional turn, rounded phase and quadrant fold.
  logic [FRAC_BITS-1:0]          sum, rnd;
  logic [PHASE_BITS-1:0]         phase;
  logic [ANG_BITS-1:0]           ang;
  logic                          fold;
  logic signed [ANG_BITS-1:0]    zf;
  logic signed [DATA_BITS+GUARD-1:0] re_sh, im_sh;
  cordic_t                       st_nxt;
  logic                          v2_r;
  cordic_t                       st2_r;

  assign sum   = px_r + py_r + pz_r;
  assign rnd   = sum + FRAC_BITS'(1 << (FRAC_BITS - PHASE_BITS - 1));
  assign phase = rnd[FRAC_BITS-1 -: PHASE_BITS];
  assign ang   = {phase, {(ANG_BITS-PHASE_BITS){1'b0}}};
  assign fold  = ang[ANG_BITS-1] ^ ang[ANG_BITS-2];
  assign zf    = {ang[ANG_BITS-1] ^ fold, ang[ANG_BITS-2:0]};
  assign re_sh = {re1_r, {GUARD{1'b0}}};
  assign im_sh = {im1_r, {GUARD{1'b0}}};

  always_comb begin
    st_nxt.byp = byp1_r;
    st_nxt.z   = ZW'(zf);
    if (byp1_r) begin
      // Bypassed samples ride through the rotator unchanged.
      st_nxt.x = CW'(re_sh);
      st_nxt.y = CW'(im_sh);
      st_nxt.z = '0;
    end else if (fold) begin
      st_nxt.x = -gre_r;
      st_nxt.y = -gim_r;
    end else begin
      st_nxt.x = gre_r;
      st_nxt.y = gim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_r <= st_nxt;
    end
  end

  assign v_out  = v2_r;
  assign st_out = st2_r;

endmodule

// ===== design/kspd_cordic.sv =====
module kspd_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_in,
  input  kspd_pkg::cordic_t st_in,
  output logic              v_out,
  output kspd_pkg::cordic_t st_out
);
  import kspd_pkg::*;

  logic    v_r  [ITERS];
  cordic_t st_r [ITERS];

  // One rotation step per register stage.
  for (genvar i = 0; i < ITERS; i++) begin : g_step
    logic    v_prev;
    cordic_t s_prev;
    cordic_t st_nxt;

    if (i == 0) begin : g_first
      assign v_prev = v_in;
      assign s_prev = st_in;
    end else begin : g_next
      assign v_prev = v_r[i-1];
      assign s_prev = st_r[i-1];
    end

    always_comb begin
      st_nxt = s_prev;
      if (!s_prev.byp) begin
        if (!s_prev.z[ZW-1]) begin
          st_nxt.x = s_prev.x - (s_prev.y >>> i);
          st_nxt.y = s_prev.y + (s_prev.x >>> i);
          st_nxt.z = s_prev.z - ZW'(ATAN_TURNS[i]);
        end else begin
          st_nxt.x = s_prev.x + (s_prev.y >>> i);
          st_nxt.y = s_prev.y - (s_prev.x >>> i);
          st_nxt.z = s_prev.z + ZW'(ATAN_TURNS[i]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  assign v_out  = v_r[ITERS-1];
  assign st_out = st_r[ITERS-1];

endmodule

// ===== design/kspd_round.sv =====
module kspd_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                v_in,
  input  kspd_pkg::cordic_t   st_in,
  output logic                v_out,
  output kspd_pkg::out_item_t res
);
  import kspd_pkg::*;

  localparam logic signed [RW-1:0] MAX_V = RW'((64'sd1 <<< (DATA_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] MIN_V = -MAX_V - RW'(1);

  logic signed [CW-1:0] sx, sy;
  logic signed [RW-1:0] rx, ry;
  logic                 hx, lx, hy, ly;
  out_item_t            res_nxt;
  logic                 v_r;
  out_item_t            res_r;

  // Round half up, then clip to the sample range.
  assign sx = st_in.x + CW'(1 << (GUARD - 1));
  assign sy = st_in.y + CW'(1 << (GUARD - 1));
  assign rx = sx[CW-1:GUARD];
  assign ry = sy[CW-1:GUARD];
  assign hx = rx > MAX_V;
  assign lx = rx < MIN_V;
  assign hy = ry > MAX_V;
  assign ly = ry < MIN_V;

  always_comb begin
    res_nxt.out_re    = hx ? MAX_V[DATA_BITS-1:0] :
                        lx ? MIN_V[DATA_BITS-1:0] : rx[DATA_BITS-1:0];
    res_nxt.out_im    = hy ? MAX_V[DATA_BITS-1:0] :
                        ly ? MIN_V[DATA_BITS-1:0] : ry[DATA_BITS-1:0];
    res_nxt.saturated = hx | lx | hy | ly;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign v_out = v_r;
  assign res   = res_r;

endmodule

// ===== design/kspace_linear_phase_demodulator.sv =====
// Linear phase ramp demodulator for k-space receive samples.
//
// Items enter on in_if: k-space coordinates and one complex sample. The block
// forms the dot product of the programmed shift with k, keeps the fractional
// turn as a 16-bit phase and rotates the sample by that phase in a 24-step
// CORDIC. Results leave on out_if with a saturation flag.
// The shift registers and axes_used are written on cfg_if, which is always
// ready; write them only while no item is in flight.
// The result passes through 27 register stages, the first loading at the input
// accept edge: two front stages (multipliers, then phase and quadrant fold),
// one register per CORDIC step, and one rounding stage that is also the output
// register. One item is taken per cycle while the pipeline is not held.
// When out_if stalls with a result waiting, the whole pipeline holds and
// in_if.ready falls; nothing is dropped or repeated. A bubble in the output
// register lets the pipeline advance regardless of out_if.ready.
// Synchronous reset clears all valid bits, sets the shifts to zero and
// axes_used to three; with zero shifts the samples pass through unchanged.
module kspace_linear_phase_demodulator (
  input  logic       clk,
  input  logic       rst_n,
  kspd_in_if.sink    in_if,
  kspd_out_if.source out_if,
  kspd_cfg_if.sink   cfg_if
);
  import kspd_pkg::*;

  cfg_t      cfg_r;
  in_item_t  item;
  logic      en;
  logic      v_front, v_cordic, v_out;
  cordic_t   st_front, st_cordic;
  out_item_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift_x   <= '0;
      cfg_r.shift_y   <= '0;
      cfg_r.shift_z   <= '0;
      cfg_r.axes_used <= AXES_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_SHIFT_X:   cfg_r.shift_x   <= cfg_if.data;
        REG_SHIFT_Y:   cfg_r.shift_y   <= cfg_if.data;
        REG_SHIFT_Z:   cfg_r.shift_z   <= cfg_if.data;
        REG_AXES_USED: cfg_r.axes_used <= cfg_if.data[AXES_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  // The pipeline advances unless a result is held at the output.
  assign en          = !v_out || out_if.ready;
  assign in_if.ready = en;

  assign item.k_x       = in_if.k_x;
  assign item.k_y       = in_if.k_y;
  assign item.k_z       = in_if.k_z;
  assign item.sample_re = in_if.sample_re;
  assign item.sample_im = in_if.sample_im;

  kspd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_in   (in_if.valid),
    .item   (item),
    .cfg    (cfg_r),
    .v_out  (v_front),
    .st_out (st_front)
  );

  kspd_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_in   (v_front),
    .st_in  (st_front),
    .v_out  (v_cordic),
    .st_out (st_cordic)
  );

  kspd_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (v_cordic),
    .st_in (st_cordic),
    .v_out (v_out),
    .res   (res)
  );

  assign out_if.valid     = v_out;
  assign out_if.out_re    = res.out_re;
  assign out_if.out_im    = res.out_im;
  assign out_if.saturated = res.saturated;

endmodule
